// File: rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Types and constants for the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int OUT_FRAC_BITS = 15;
	localparam int CORDIC_STEPS  = 16;
	localparam int STEP_LIMIT    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int WORK_FRAC     = 30;
	localparam int OUT_W         = OUT_FRAC_BITS + 1;
	localparam int CW            = 34;   // cordic x/y/z width
	localparam int PW            = 32;   // product operand width
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] roll_angle;
		logic signed [ANGLE_BITS-1:0] pitch_angle;
		logic signed [ANGLE_BITS-1:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] quat_w;
		logic signed [OUT_W-1:0] quat_x;
		logic signed [OUT_W-1:0] quat_y;
		logic signed [OUT_W-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} rot_t;

	function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
		logic [31:0] t;
		unique case (i)
			5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E;
			5'd2:  t = 32'h09FB385B; 5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53; 5'd9:  t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
			5'd30: t = 32'h00000001; 5'd31: t = 32'h00000000;
			default: t = 32'h0;
		endcase
		return $signed({1'b0, t, 1'b0});
	endfunction

endpackage

// File: rtl/euler_to_quaternion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Roll, pitch and yaw binary angles to a ZYX unit quaternion in Q1.15.
// ----------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  angles   | start, busy, angles    | transfer when start && !busy
//  quat     | done, quat             | done high one cycle, always taken
//
// One item per cycle; the pipeline holds STEP_LIMIT (16) CORDIC
// iteration stages, two multiply ranks, an add rank, and round and saturate.
// busy is tied low: nothing downstream can stall. Reset clears valid bits
// only; the data path has no reset.
module euler_to_quaternion_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  e2q_pkg::angles_t angles,
	output logic            done,
	output e2q_pkg::quat_t  quat
);
	logic vr, vp, vy, acc;
	logic signed [e2q_pkg::PW-1:0] cr, sr, cp, sp, cy, sy;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	e2q_sincos u_roll (.clk(clk), .arst_n(arst_n), .vld(acc), .angle(angles.roll_angle),
		.vld_out(vr), .cos_q(cr), .sin_q(sr));
	e2q_sincos u_pitch (.clk(clk), .arst_n(arst_n), .vld(acc), .angle(angles.pitch_angle),
		.vld_out(vp), .cos_q(cp), .sin_q(sp));
	e2q_sincos u_yaw (.clk(clk), .arst_n(arst_n), .vld(acc), .angle(angles.yaw_angle),
		.vld_out(vy), .cos_q(cy), .sin_q(sy));

	e2q_combine u_comb (
		.clk(clk), .arst_n(arst_n), .vld(vr & vp & vy),
		.cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.vld_out(done), .q(quat)
	);
endmodule

// File: rtl/e2q_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic_stage
// One registered rotation-mode CORDIC iteration; step index fixed by port.
// ----------------------------------------------------------------------------
module e2q_cordic_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [4:0]     step,
	input  logic           vld,
	input  e2q_pkg::rot_t  din,
	output logic           vld_out,
	output e2q_pkg::rot_t  dout
);
	logic signed [e2q_pkg::CW-1:0] dx, dy, t;
	e2q_pkg::rot_t nxt;

	always_comb begin
		dx = din.y >>> step;
		dy = din.x >>> step;
		t  = e2q_pkg::atan_step(step);
		if (!din.z[e2q_pkg::CW-1]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - t;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule

// File: rtl/e2q_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_sincos
// Unrolled, fully pipelined CORDIC: half angle in, cos and sin (Q30) out.
// ----------------------------------------------------------------------------
module e2q_sincos (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 vld,
	input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle,
	output logic                                 vld_out,
	output logic signed [e2q_pkg::PW-1:0]        cos_q,
	output logic signed [e2q_pkg::PW-1:0]        sin_q
);
	localparam int N = e2q_pkg::STEP_LIMIT;

	e2q_pkg::rot_t r [N+1];
	logic          v [N+1];

	always_comb begin
		r[0].x = e2q_pkg::CORDIC_GAIN;
		r[0].y = '0;
		r[0].z = {{(e2q_pkg::CW-e2q_pkg::ANGLE_BITS){angle[e2q_pkg::ANGLE_BITS-1]}},
			angle} <<< (32 - e2q_pkg::ANGLE_BITS);
		v[0] = vld;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		e2q_cordic_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (5'(i)),
			.vld    (v[i]),
			.din    (r[i]),
			.vld_out(v[i+1]),
			.dout   (r[i+1])
		);
	end

	assign vld_out = v[N];
	assign cos_q   = r[N].x[e2q_pkg::PW-1:0];
	assign sin_q   = r[N].y[e2q_pkg::PW-1:0];
endmodule

// File: rtl/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Pair products, triple products, sums, rounding and saturation; 4 stages.
// ----------------------------------------------------------------------------
module e2q_combine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld,
	input  logic signed [e2q_pkg::PW-1:0] cr, sr, cp, sp, cy, sy,
	output logic                          vld_out,
	output e2q_pkg::quat_t                q
);
	localparam int SH = e2q_pkg::WORK_FRAC - e2q_pkg::OUT_FRAC_BITS;
	localparam int SW = e2q_pkg::PW + 2;
	localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< e2q_pkg::OUT_FRAC_BITS) - 1);
	localparam logic signed [SW-1:0] LO = -HI - 1;

	logic signed [e2q_pkg::PW-1:0] cc_s1, ss_s1, sc_s1, cs_s1, cy_s1, sy_s1;
	logic signed [e2q_pkg::PW-1:0] t_s2 [8];
	logic signed [SW-1:0] w_s3, x_s3, y_s3, z_s3;
	logic v_s1, v_s2, v_s3, v_s4;
	e2q_pkg::quat_t q_s4;

	function automatic logic signed [e2q_pkg::PW-1:0] qmul(
		input logic signed [e2q_pkg::PW-1:0] a, input logic signed [e2q_pkg::PW-1:0] b);
		logic signed [2*e2q_pkg::PW-1:0] p;
		p = a * b;
		return p[e2q_pkg::WORK_FRAC +: e2q_pkg::PW];
	endfunction

	function automatic logic signed [e2q_pkg::OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = (v + SW'(64'sd1 <<< (SH - 1))) >>> SH;
		if (r > HI) r = HI;
		if (r < LO) r = LO;
		return r[e2q_pkg::OUT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= vld; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cc_s1 <= qmul(cr, cp);
		ss_s1 <= qmul(sr, sp);
		sc_s1 <= qmul(sr, cp);
		cs_s1 <= qmul(cr, sp);
		cy_s1 <= cy;
		sy_s1 <= sy;
		t_s2[0] <= qmul(cc_s1, cy_s1);
		t_s2[1] <= qmul(ss_s1, sy_s1);
		t_s2[2] <= qmul(sc_s1, cy_s1);
		t_s2[3] <= qmul(cs_s1, sy_s1);
		t_s2[4] <= qmul(cs_s1, cy_s1);
		t_s2[5] <= qmul(sc_s1, sy_s1);
		t_s2[6] <= qmul(cc_s1, sy_s1);
		t_s2[7] <= qmul(ss_s1, cy_s1);
		w_s3 <= SW'(t_s2[0]) + SW'(t_s2[1]);
		x_s3 <= SW'(t_s2[2]) - SW'(t_s2[3]);
		y_s3 <= SW'(t_s2[4]) + SW'(t_s2[5]);
		z_s3 <= SW'(t_s2[6]) - SW'(t_s2[7]);
		q_s4.quat_w <= to_out(w_s3);
		q_s4.quat_x <= to_out(x_s3);
		q_s4.quat_y <= to_out(y_s3);
		q_s4.quat_z <= to_out(z_s3);
	end

	assign vld_out = v_s4;
	assign q       = q_s4;
endmodule
